// ===== sv/lsfs_pkg.sv =====
// Shared types, constants and arithmetic helpers of the lightning scene fade sequencer.
`timescale 1ns / 1ps

package lsfs_pkg;

    // Sequencer constants
    localparam int FADE_DIVISOR = 8;
    localparam int MIN_FLASHES  = 3;
    localparam int MAX_FLASHES  = 10;
    localparam int MAX_WAIT_MS  = 1000;
    localparam int MAX_BURST    = 4;

    localparam logic [15:0] LIGHTNING_WAIT_MS = 16'd1000;

    // Reset values of the configuration registers
    localparam logic [7:0]  NIGHT_LEVEL_RST = 8'd20;
    localparam logic [15:0] FADE_PERIOD_RST = 16'd20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_PERIOD = 1'b1;

    // Request codes
    localparam logic REQ_ENTER = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Phase codes as seen on the result channel
    localparam logic [1:0] PHASE_CODE_IDLE      = 2'd0;
    localparam logic [1:0] PHASE_CODE_DARKEN    = 2'd1;
    localparam logic [1:0] PHASE_CODE_LIGHTNING = 2'd2;
    localparam logic [1:0] PHASE_CODE_BRIGHTEN  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_DARKEN    = 4'b0010,
        PH_LIGHTNING = 4'b0100,
        PH_BRIGHTEN  = 4'b1000
    } t_phase;

    // Effective divisors and their reciprocals, all worked out at elaboration
    localparam bit FLASH_SPAN_OK = (MAX_FLASHES > MIN_FLASHES);
    localparam int FLASH_SPAN    = FLASH_SPAN_OK ? (MAX_FLASHES - MIN_FLASHES) : 1;
    localparam int FADE_DIV_EFF  = (FADE_DIVISOR == 0) ? 1 : FADE_DIVISOR;

    localparam logic [32:0] RECIP_FLASH = 33'(64'h1_0000_0000 / 64'(FLASH_SPAN));
    localparam logic [32:0] RECIP_WAIT  = 33'(64'h1_0000_0000 / 64'(MAX_WAIT_MS));
    localparam logic [32:0] RECIP_BURST = 33'(64'h1_0000_0000 / 64'(MAX_BURST));
    localparam logic [16:0] FADE_RECIP  = 17'((65536 + FADE_DIV_EFF - 1) / FADE_DIV_EFF);

    localparam logic [15:0] FLASH_SPAN_W  = 16'(FLASH_SPAN);
    localparam logic [15:0] MAX_WAIT_W    = 16'(MAX_WAIT_MS);
    localparam logic [15:0] MAX_BURST_W   = 16'(MAX_BURST);
    localparam logic [7:0]  MIN_FLASHES_W = 8'(MIN_FLASHES);

    // Registered item between the input stage and the step stage
    typedef struct packed {
        logic             req_type;
        logic [3:0][15:0] prod;      // scene colour times brightness, per channel
        logic [15:0]      rlo;
        logic [15:0]      rhi;
        logic [15:0]      q_flash;   // quotient estimates, at most one low
        logic [15:0]      q_wait;
        logic [15:0]      q_burst;
    } t_item;

    typedef struct packed {
        logic [7:0] level;
        logic       reached;
    } t_fade;

    // Quotient estimate of x by a constant through its 2^32 reciprocal
    function automatic logic [15:0] quot_est(input logic [15:0] x, input logic [32:0] recip);
        logic [48:0] p;
        p = 49'(x) * 49'(recip);
        return p[47:32];
    endfunction

    // Remainder from a quotient estimate that may be one low
    function automatic logic [15:0] rem_fix(input logic [15:0] x, input logic [15:0] q,
                                            input logic [15:0] d);
        logic [31:0] qd;
        logic [31:0] r;
        qd = 32'(q) * 32'(d);
        r  = 32'(x) - qd;
        if (r >= 32'(d)) begin
            r = r - 32'(d);
        end
        return r[15:0];
    endfunction

    // Floor of a 16-bit product over 255
    function automatic logic [7:0] scale_div(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // One fade step of a channel toward its target
    function automatic t_fade fade_ch(input logic [7:0] tgt, input logic [7:0] cur);
        logic [24:0] p;
        logic [8:0]  step;
        logic [9:0]  up;
        t_fade       f;
        p         = 25'(cur) * 25'(FADE_RECIP);
        step      = 9'(p[23:16]) + 9'd1;
        up        = 10'(cur) + 10'(step);
        f.level   = cur;
        f.reached = 1'b0;
        if (tgt < cur) begin
            f.level = (step < 9'(cur)) ? 8'(9'(cur) - step) : 8'd0;
            if (tgt > f.level) begin
                f.level   = tgt;
                f.reached = 1'b1;
            end
        end else if (tgt > cur) begin
            if (10'(tgt) > up) begin
                f.level = up[7:0];
            end else begin
                f.level   = tgt;
                f.reached = 1'b1;
            end
        end else begin
            f.reached = 1'b1;
        end
        return f;
    endfunction

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] c;
        case (ph)
            PH_IDLE:      c = PHASE_CODE_IDLE;
            PH_DARKEN:    c = PHASE_CODE_DARKEN;
            PH_LIGHTNING: c = PHASE_CODE_LIGHTNING;
            PH_BRIGHTEN:  c = PHASE_CODE_BRIGHTEN;
            default:      c = PHASE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/lsfs_if.sv =====
// Channel interfaces: request items, result items and configuration writes.
`timescale 1ns / 1ps

interface lsfs_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  scene_red;
    logic [7:0]  scene_green;
    logic [7:0]  scene_blue;
    logic [7:0]  scene_white;
    logic [7:0]  scene_brightness;
    logic [31:0] random_value;

    modport source (output valid, req_type, scene_red, scene_green, scene_blue,
                    scene_white, scene_brightness, random_value, input ready);
    modport sink   (input valid, req_type, scene_red, scene_green, scene_blue,
                    scene_white, scene_brightness, random_value, output ready);
endinterface

interface lsfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_white;
    logic       show_update;
    logic [1:0] phase;
    logic [7:0] burst_count;
    logic       scene_exit;

    modport source (output valid, out_red, out_green, out_blue, out_white, show_update,
                    phase, burst_count, scene_exit, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_white, show_update,
                    phase, burst_count, scene_exit, output ready);
endinterface

interface lsfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/lsfs_in_stage.sv =====
// Input register: captures a request and precomputes products and quotient estimates.
`timescale 1ns / 1ps

module lsfs_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lsfs_in_if.sink         i_in,
    input  logic            i_advance,
    output logic            o_valid,
    output lsfs_pkg::t_item o_item
);
    import lsfs_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    // Accept while empty or while the held item moves on
    assign i_in.ready = !r_valid || i_advance;
    assign take       = i_in.valid && i_in.ready;

    // Precompute scene products and quotient estimates of the random draw
    always_comb begin
        n_item.req_type = i_in.req_type;
        n_item.prod[0]  = 16'(i_in.scene_red)   * 16'(i_in.scene_brightness);
        n_item.prod[1]  = 16'(i_in.scene_green) * 16'(i_in.scene_brightness);
        n_item.prod[2]  = 16'(i_in.scene_blue)  * 16'(i_in.scene_brightness);
        n_item.prod[3]  = 16'(i_in.scene_white) * 16'(i_in.scene_brightness);
        n_item.rlo      = i_in.random_value[15:0];
        n_item.rhi      = i_in.random_value[31:16];
        n_item.q_flash  = quot_est(i_in.random_value[15:0], RECIP_FLASH);
        n_item.q_wait   = quot_est(i_in.random_value[15:0], RECIP_WAIT);
        n_item.q_burst  = quot_est(i_in.random_value[31:16], RECIP_BURST);
    end

    // Hold valid until the step stage takes the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/lsfs_core.sv =====
// Scene state, one step per item, and the result register.
`timescale 1ns / 1ps

module lsfs_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lsfs_pkg::t_item i_item,
    output logic            o_advance,
    input  logic [7:0]      i_night_level,
    input  logic [15:0]     i_fade_period,
    lsfs_out_if.source      o_res
);
    import lsfs_pkg::*;

    t_phase          r_phase,   n_phase;
    logic [3:0][7:0] r_bg,      n_bg;
    logic [3:0][7:0] r_target,  n_target;
    logic [15:0]     r_elapsed, n_elapsed;
    logic [15:0]     r_timeout, n_timeout;
    logic [7:0]      r_total,   n_total;
    logic [7:0]      r_done,    n_done;

    logic            r_out_valid;
    logic            r_show,  n_show;
    logic [7:0]      r_burst, n_burst;
    logic            r_exit,  n_exit;

    logic            step_go;
    logic [15:0]     elapsed_inc;
    logic            fire;
    logic [3:0][7:0] scaled;
    logic [3:0][7:0] fade_tgt;
    t_fade [3:0]     fade;
    logic            fade_done;
    logic [15:0]     rem_flash;
    logic [15:0]     rem_wait;
    logic [15:0]     rem_burst;

    // Step an item whenever the result register is free or being drained
    assign o_advance = !r_out_valid || o_res.ready;
    assign step_go   = i_valid && o_advance;

    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? (r_elapsed + 16'd1) : r_elapsed;
    assign fire        = (elapsed_inc >= r_timeout);

    // Finish the random draws from their quotient estimates
    assign rem_flash = rem_fix(i_item.rlo, i_item.q_flash, FLASH_SPAN_W);
    assign rem_wait  = rem_fix(i_item.rlo, i_item.q_wait,  MAX_WAIT_W);
    assign rem_burst = rem_fix(i_item.rhi, i_item.q_burst, MAX_BURST_W);

    // Fade all channels toward darkness or back to the scene
    always_comb begin
        fade_done = 1'b1;
        for (int i = 0; i < 4; i++) begin
            scaled[i] = scale_div(i_item.prod[i]);
            if (r_phase == PH_DARKEN) begin
                fade_tgt[i] = (i == 2) ? i_night_level : 8'd0;
            end else begin
                fade_tgt[i] = r_target[i];
            end
            fade[i] = fade_ch(fade_tgt[i], r_bg[i]);
            fade_done = fade_done && fade[i].reached;
        end
    end

    // Next scene state and result
    always_comb begin
        n_phase   = r_phase;
        n_bg      = r_bg;
        n_target  = r_target;
        n_elapsed = r_elapsed;
        n_timeout = r_timeout;
        n_total   = r_total;
        n_done    = r_done;
        n_show    = 1'b0;
        n_burst   = 8'd0;
        n_exit    = 1'b0;
        if (i_item.req_type == REQ_ENTER) begin
            n_bg      = scaled;
            n_target  = scaled;
            n_timeout = i_fade_period;
            n_elapsed = 16'd0;
            n_phase   = PH_DARKEN;
        end else if (r_phase != PH_IDLE) begin
            n_elapsed = elapsed_inc;
            if (fire) begin
                n_elapsed = 16'd0;
                case (r_phase)
                    PH_DARKEN: begin
                        n_show = 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            n_bg[i] = fade[i].level;
                        end
                        if (fade_done) begin
                            n_phase   = PH_LIGHTNING;
                            n_total   = FLASH_SPAN_OK ? (rem_flash[7:0] + MIN_FLASHES_W)
                                                      : MIN_FLASHES_W;
                            n_done    = 8'd0;
                            n_timeout = LIGHTNING_WAIT_MS;
                        end
                    end
                    PH_LIGHTNING: begin
                        if (r_done >= r_total) begin
                            n_phase   = PH_BRIGHTEN;
                            n_timeout = i_fade_period;
                        end else begin
                            n_timeout = rem_wait;
                            n_burst   = rem_burst[7:0];
                            n_done    = r_done + 8'd1;
                        end
                    end
                    PH_BRIGHTEN: begin
                        n_show = 1'b1;
                        for (int i = 0; i < 4; i++) begin
                            n_bg[i] = fade[i].level;
                        end
                        if (fade_done) begin
                            n_exit  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Scene state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bg      <= '0;
            r_target  <= '0;
            r_elapsed <= 16'd0;
            r_timeout <= 16'd0;
            r_total   <= 8'd0;
            r_done    <= 8'd0;
        end else if (step_go) begin
            r_phase   <= n_phase;
            r_bg      <= n_bg;
            r_target  <= n_target;
            r_elapsed <= n_elapsed;
            r_timeout <= n_timeout;
            r_total   <= n_total;
            r_done    <= n_done;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid;
        end
    end

    // Result flags; colour and phase come from the state just written
    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_show  <= n_show;
            r_burst <= n_burst;
            r_exit  <= n_exit;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_red     = r_bg[0];
    assign o_res.out_green   = r_bg[1];
    assign o_res.out_blue    = r_bg[2];
    assign o_res.out_white   = r_bg[3];
    assign o_res.show_update = r_show;
    assign o_res.phase       = phase_code(r_phase);
    assign o_res.burst_count = r_burst;
    assign o_res.scene_exit  = r_exit;

endmodule

// ===== sv/lightning_scene_fade_sequencer_top.sv =====
// Top level: configuration registers and the two-stage scene sequencer.
// The input register captures a request at its transfer edge; the step stage then
// writes scene state and the result register when that item advances.
// Throughput: one request per cycle while results are taken; the result register
// holds scene state, so a stalled result stops the step stage and the input register.
// Reset (i_rst_n low at a clock edge): phase idle, colours and counters zero,
// night level 20, fade period 20 ms, both channel registers empty.
`timescale 1ns / 1ps

module lightning_scene_fade_sequencer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsfs_in_if.sink    i_in,
    lsfs_out_if.source o_res,
    lsfs_cfg_if.sink   i_cfg
);
    import lsfs_pkg::*;

    logic [7:0]  r_night_level;
    logic [15:0] r_fade_period;
    logic        item_valid;
    logic        advance;
    t_item       item;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_night_level <= NIGHT_LEVEL_RST;
            r_fade_period <= FADE_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NIGHT_LEVEL: r_night_level <= i_cfg.data[7:0];
                CFG_FADE_PERIOD: r_fade_period <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    lsfs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    lsfs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (item_valid),
        .i_item        (item),
        .o_advance     (advance),
        .i_night_level (r_night_level),
        .i_fade_period (r_fade_period),
        .o_res         (o_res)
    );

endmodule
